// File: rtl/polygon_area_centroid_normal_unit_defines.svh
// ---------------------------------------------------------------------------
// Polygon area, centroid and normal unit: assertion macros
// Shared macros for the concurrent checks on the unit's ports.
// ---------------------------------------------------------------------------
`ifndef POLYGON_AREA_CENTROID_NORMAL_UNIT_DEFINES_SVH
`define POLYGON_AREA_CENTROID_NORMAL_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PACN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PACN_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pacn_pkg.sv
// ---------------------------------------------------------------------------
// Polygon area, centroid and normal package
// Widths, word types and vertex classes shared by the unit's modules.
// ---------------------------------------------------------------------------
package pacn_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MIN_POLY     = 3;
  localparam int COORD_W      = 24;
  localparam int CNT_W        = 7;
  localparam int SUM_W        = 31;
  localparam int NEWELL_W     = 58;
  localparam int AREA_SUM_W   = 59;
  localparam int AREA_W       = 58;
  localparam int NORMAL_W     = 32;
  localparam int OPND_W       = 25;
  localparam int PROD_W       = 50;
  localparam int SQ_W         = 116;
  localparam int ROOT_W       = 58;
  localparam int RREM_W       = 60;
  localparam int QUO_W        = 31;
  localparam int CREM_W       = 8;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;
  localparam int QFILL_W      = 3;

  // One input word: a vertex and its end-of-polygon mark.
  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic                      last_vertex;
  } vertex_word_t;

  // One result word.
  typedef struct packed {
    logic [AREA_W-1:0]          area;
    logic signed [COORD_W-1:0]  centroid_x;
    logic signed [COORD_W-1:0]  centroid_y;
    logic signed [COORD_W-1:0]  centroid_z;
    logic signed [NORMAL_W-1:0] unit_normal_x;
    logic signed [NORMAL_W-1:0] unit_normal_y;
    logic signed [NORMAL_W-1:0] unit_normal_z;
    logic [CNT_W-1:0]           vertices_used;
    logic                       normal_degenerate;
    logic                       vertex_overflow;
  } result_word_t;

  // Role of a vertex within its polygon, decided at the front.
  typedef enum logic [1:0] {
    KIND_FIRST    = 2'd0,
    KIND_SECOND   = 2'd1,
    KIND_TRIANGLE = 2'd2,
    KIND_DROPPED  = 2'd3
  } vertex_kind_t;

  typedef struct packed {
    vertex_kind_t kind;
    vertex_word_t vtx;
  } queue_word_t;

  // Write side of the queue.
  typedef struct packed {
    logic        en;
    queue_word_t word;
  } queue_wr_t;

  // Read side of the queue.
  typedef struct packed {
    logic        valid;
    queue_word_t word;
  } queue_rd_t;

endpackage

// File: rtl/pacn_front.sv
// ---------------------------------------------------------------------------
// Polygon front end
// Accepts vertex words and tags each one with its role in the polygon.
// ---------------------------------------------------------------------------
module pacn_front import pacn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  input  vertex_word_t in_data,
  output logic         in_full,
  input  logic         q_full,
  output queue_wr_t    wr
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             accept;
  vertex_kind_t     kind;

  assign accept  = in_push & ~q_full;
  assign in_full = q_full;

  // Classify the vertex by how many vertices came before it.
  always_comb begin
    if (count_r == CNT_W'(MAX_VERTICES)) begin
      kind = KIND_DROPPED;
    end else if (count_r == '0) begin
      kind = KIND_FIRST;
    end else if (count_r == CNT_W'(1)) begin
      kind = KIND_SECOND;
    end else begin
      kind = KIND_TRIANGLE;
    end
  end

  // The count restarts after the last vertex and stops at the maximum.
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (in_data.last_vertex) begin
        count_nxt = '0;
      end else if (kind != KIND_DROPPED) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign wr.en        = accept;
  assign wr.word.kind = kind;
  assign wr.word.vtx  = in_data;

endmodule

// File: rtl/pacn_queue.sv
// ---------------------------------------------------------------------------
// Polygon vertex queue
// Short first-in first-out buffer between the front end and the back end.
// ---------------------------------------------------------------------------
module pacn_queue import pacn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  queue_wr_t wr,
  output logic      full,
  output queue_rd_t rd,
  input  logic      pop
);

  queue_word_t        entry_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QFILL_W-1:0] fill_r;
  logic               do_wr;
  logic               do_rd;

  assign full     = (fill_r == QFILL_W'(QDEPTH));
  assign rd.valid = (fill_r != '0);
  assign rd.word  = entry_r[rd_ptr_r];
  assign do_wr    = wr.en & ~full;
  assign do_rd    = pop & rd.valid;

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr.word;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill_r <= fill_r + QFILL_W'(1);
      end else if (!do_wr && do_rd) begin
        fill_r <= fill_r - QFILL_W'(1);
      end
    end
  end

endmodule

// File: rtl/pacn_back.sv
// ---------------------------------------------------------------------------
// Polygon back end
// Runs the per-vertex sums, the bit-serial square and root unit and the
// final divisions, and holds the result word until it is taken.
// ---------------------------------------------------------------------------
module pacn_back import pacn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  queue_rd_t    rd,
  output logic         pop,
  output logic         out_empty,
  input  logic         out_pop,
  output result_word_t out_data
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_UPD   = 12'b000000000010,
    ST_MUL   = 12'b000000000100,
    ST_DRAIN = 12'b000000001000,
    ST_SQL   = 12'b000000010000,
    ST_SQ    = 12'b000000100000,
    ST_RTL   = 12'b000001000000,
    ST_RT    = 12'b000010000000,
    ST_AREA  = 12'b000100000000,
    ST_DIVL  = 12'b001000000000,
    ST_DIV   = 12'b010000000000,
    ST_OUT   = 12'b100000000000
  } state_t;

  // Product steps: three Newell terms, then the six cross product terms.
  localparam logic [3:0] MS_NX   = 4'd0;
  localparam logic [3:0] MS_NY   = 4'd1;
  localparam logic [3:0] MS_NZ   = 4'd2;
  localparam logic [3:0] MS_CX_P = 4'd3;
  localparam logic [3:0] MS_CX_N = 4'd4;
  localparam logic [3:0] MS_CY_P = 4'd5;
  localparam logic [3:0] MS_CY_N = 4'd6;
  localparam logic [3:0] MS_CZ_P = 4'd7;
  localparam logic [3:0] MS_CZ_N = 4'd8;

  function automatic logic [NEWELL_W-1:0] mag58(input logic signed [NEWELL_W-1:0] v);
    return v[NEWELL_W-1] ? NEWELL_W'(-v) : NEWELL_W'(v);
  endfunction

  function automatic logic signed [OPND_W-1:0] ext25(input logic signed [COORD_W-1:0] v);
    return {v[COORD_W-1], v};
  endfunction

  state_t state_r;
  state_t state_nxt;

  // Polygon state.
  queue_word_t               cur_r;
  logic                      fin_r;
  logic signed [COORD_W-1:0] first_r  [3];
  logic signed [COORD_W-1:0] prev_r   [3];
  logic [CNT_W-1:0]          count_r;
  logic [AREA_SUM_W-1:0]     area_r;
  logic signed [SUM_W-1:0]   csum_r   [3];
  logic signed [NEWELL_W-1:0] newell_r [3];
  logic                      ovf_r;

  // Work registers.
  logic signed [NEWELL_W-1:0] cross_r [3];
  logic [3:0]                 ms_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [3:0]                 ptag_r;
  logic                       pv_r;
  logic [1:0]                 comp_r;
  logic [5:0]                 bit_r;
  logic [SQ_W-1:0]            mcand_r;
  logic [ROOT_W-1:0]          mplier_r;
  logic [SQ_W-1:0]            acc_r;
  logic [SQ_W-1:0]            rad_r;
  logic [ROOT_W-1:0]          root_r;
  logic [RREM_W-1:0]          rrem_r;
  logic [ROOT_W-1:0]          len_r;
  logic                       degen_r;
  logic [AREA_SUM_W-1:0]      nrem_r [3];
  logic [QUO_W-1:0]           nq_r   [3];
  logic [QUO_W-1:0]           cdiv_r [3];
  logic [CREM_W-1:0]          crem_r [3];
  logic [QUO_W-1:0]           cq_r   [3];
  logic [4:0]                 dcnt_r;

  result_word_t out_r;
  logic         out_valid_r;

  // Combinational helpers.
  logic signed [COORD_W-1:0]  cur_v [3];
  logic signed [COORD_W-1:0]  nb_v  [3];
  logic signed [OPND_W-1:0]   opa;
  logic signed [OPND_W-1:0]   opb;
  logic signed [PROD_W-1:0]   prod_c;
  logic [3:0]                 ms_end;
  logic [NEWELL_W-1:0]        sq_src;
  logic [RREM_W-1:0]          rem_sh;
  logic [RREM_W-1:0]          trial;
  logic                       rt_ge;
  logic [AREA_SUM_W:0]        asum;
  logic                       big_poly;
  logic [ROOT_W-1:0]          len_c;
  logic                       nge   [3];
  logic [CREM_W-1:0]          crsh  [3];
  logic                       cge   [3];
  logic [SUM_W-1:0]           cmag  [3];
  logic [QUO_W-1:0]           cent  [3];
  logic [NORMAL_W-1:0]        nrm   [3];
  logic                       out_load;

  assign cur_v[0] = cur_r.vtx.vertex_x;
  assign cur_v[1] = cur_r.vtx.vertex_y;
  assign cur_v[2] = cur_r.vtx.vertex_z;
  assign big_poly = (count_r >= CNT_W'(MIN_POLY));
  assign pop      = (state_r == ST_IDLE) && rd.valid;
  assign out_load = (state_r == ST_OUT) && !out_valid_r;

  // The closing edge runs from the previous vertex back to the first.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nb_v[i] = fin_r ? first_r[i] : cur_v[i];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ms_r)
      MS_NX: begin
        opa = ext25(prev_r[1]) - ext25(nb_v[1]);
        opb = ext25(prev_r[2]) + ext25(nb_v[2]);
      end
      MS_NY: begin
        opa = ext25(prev_r[2]) - ext25(nb_v[2]);
        opb = ext25(prev_r[0]) + ext25(nb_v[0]);
      end
      MS_NZ: begin
        opa = ext25(prev_r[0]) - ext25(nb_v[0]);
        opb = ext25(prev_r[1]) + ext25(nb_v[1]);
      end
      MS_CX_P: begin
        opa = ext25(prev_r[1]) - ext25(first_r[1]);
        opb = ext25(cur_v[2]) - ext25(first_r[2]);
      end
      MS_CX_N: begin
        opa = ext25(prev_r[2]) - ext25(first_r[2]);
        opb = ext25(cur_v[1]) - ext25(first_r[1]);
      end
      MS_CY_P: begin
        opa = ext25(prev_r[2]) - ext25(first_r[2]);
        opb = ext25(cur_v[0]) - ext25(first_r[0]);
      end
      MS_CY_N: begin
        opa = ext25(prev_r[0]) - ext25(first_r[0]);
        opb = ext25(cur_v[2]) - ext25(first_r[2]);
      end
      MS_CZ_P: begin
        opa = ext25(prev_r[0]) - ext25(first_r[0]);
        opb = ext25(cur_v[1]) - ext25(first_r[1]);
      end
      MS_CZ_N: begin
        opa = ext25(prev_r[1]) - ext25(first_r[1]);
        opb = ext25(cur_v[0]) - ext25(first_r[0]);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_c = opa * opb;
  assign ms_end = (fin_r || cur_r.kind == KIND_SECOND) ? MS_NZ : MS_CZ_N;
  assign sq_src = fin_r ? mag58(newell_r[comp_r]) : mag58(cross_r[comp_r]);

  // One root bit per cycle: compare the remainder with 4*root+1.
  assign rem_sh = {rrem_r[RREM_W-3:0], rad_r[SQ_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign rt_ge  = (rem_sh >= trial);

  assign asum  = {1'b0, area_r} + (AREA_SUM_W+1)'(root_r);
  assign len_c = big_poly ? root_r : '0;

  // Division lanes: three normal components and three centroid coordinates.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nge[i]  = (nrem_r[i] >= {1'b0, len_r});
      crsh[i] = {crem_r[i][CREM_W-2:0], cdiv_r[i][QUO_W-1]};
      cge[i]  = (crsh[i] >= {1'b0, count_r});
      cmag[i] = csum_r[i][SUM_W-1] ? SUM_W'(-csum_r[i]) : SUM_W'(csum_r[i]);
      cent[i] = csum_r[i][SUM_W-1] ? QUO_W'(-cq_r[i]) : cq_r[i];
      nrm[i]  = newell_r[i][NEWELL_W-1] ? NORMAL_W'(-{1'b0, nq_r[i]})
                                        : NORMAL_W'({1'b0, nq_r[i]});
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (rd.valid) begin
          unique case (rd.word.kind)
            KIND_FIRST:   state_nxt = ST_UPD;
            KIND_DROPPED: state_nxt = rd.word.vtx.last_vertex ? ST_MUL : ST_IDLE;
            default:      state_nxt = ST_MUL;
          endcase
        end
      end
      ST_UPD:   state_nxt = cur_r.vtx.last_vertex ? ST_MUL : ST_IDLE;
      ST_MUL:   state_nxt = (ms_r == ms_end) ? ST_DRAIN : ST_MUL;
      ST_DRAIN: begin
        if (fin_r) begin
          state_nxt = big_poly ? ST_SQL : ST_DIVL;
        end else begin
          state_nxt = (cur_r.kind == KIND_TRIANGLE) ? ST_SQL : ST_UPD;
        end
      end
      ST_SQL:   state_nxt = ST_SQ;
      ST_SQ: begin
        if (bit_r == 6'(ROOT_W-1)) begin
          state_nxt = (comp_r == 2'd2) ? ST_RTL : ST_SQL;
        end
      end
      ST_RTL:   state_nxt = ST_RT;
      ST_RT: begin
        if (bit_r == 6'(ROOT_W-1)) begin
          state_nxt = fin_r ? ST_DIVL : ST_AREA;
        end
      end
      ST_AREA:  state_nxt = ST_UPD;
      ST_DIVL:  state_nxt = ST_DIV;
      ST_DIV:   state_nxt = (dcnt_r == 5'(QUO_W-1)) ? ST_OUT : ST_DIV;
      ST_OUT:   state_nxt = out_valid_r ? ST_OUT : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control and polygon state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fin_r       <= 1'b0;
      count_r     <= '0;
      area_r      <= '0;
      ovf_r       <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        first_r[i]  <= '0;
        prev_r[i]   <= '0;
        csum_r[i]   <= '0;
        newell_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      pv_r    <= (state_r == ST_MUL);

      // Fold the registered product into its sum.
      if (pv_r) begin
        case (ptag_r)
          MS_NX:   newell_r[0] <= newell_r[0] + NEWELL_W'(prod_r);
          MS_NY:   newell_r[1] <= newell_r[1] + NEWELL_W'(prod_r);
          MS_NZ:   newell_r[2] <= newell_r[2] + NEWELL_W'(prod_r);
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (rd.valid) begin
            if (rd.word.kind == KIND_DROPPED) begin
              ovf_r <= 1'b1;
              fin_r <= rd.word.vtx.last_vertex;
            end else if (rd.word.kind == KIND_FIRST) begin
              first_r[0] <= rd.word.vtx.vertex_x;
              first_r[1] <= rd.word.vtx.vertex_y;
              first_r[2] <= rd.word.vtx.vertex_z;
            end
          end
        end
        ST_UPD: begin
          for (int i = 0; i < 3; i++) begin
            csum_r[i] <= csum_r[i] + SUM_W'(cur_v[i]);
            prev_r[i] <= cur_v[i];
          end
          count_r <= count_r + CNT_W'(1);
          fin_r   <= cur_r.vtx.last_vertex;
        end
        ST_AREA: begin
          area_r <= asum[AREA_SUM_W] ? '1 : asum[AREA_SUM_W-1:0];
        end
        ST_OUT: begin
          if (!out_valid_r) begin
            fin_r   <= 1'b0;
            count_r <= '0;
            area_r  <= '0;
            ovf_r   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              first_r[i]  <= '0;
              prev_r[i]   <= '0;
              csum_r[i]   <= '0;
              newell_r[i] <= '0;
            end
          end
        end
        default: ;
      endcase

      // Result word handshake.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath work registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_c;
    ptag_r <= ms_r;
    if (pv_r) begin
      case (ptag_r)
        MS_CX_P: cross_r[0] <= NEWELL_W'(prod_r);
        MS_CX_N: cross_r[0] <= cross_r[0] - NEWELL_W'(prod_r);
        MS_CY_P: cross_r[1] <= NEWELL_W'(prod_r);
        MS_CY_N: cross_r[1] <= cross_r[1] - NEWELL_W'(prod_r);
        MS_CZ_P: cross_r[2] <= NEWELL_W'(prod_r);
        MS_CZ_N: cross_r[2] <= cross_r[2] - NEWELL_W'(prod_r);
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (rd.valid) begin
          cur_r <= rd.word;
        end
        ms_r <= MS_NX;
      end
      ST_UPD: begin
        ms_r <= MS_NX;
      end
      ST_MUL: begin
        ms_r <= ms_r + 4'd1;
      end
      ST_DRAIN: begin
        comp_r <= 2'd0;
        acc_r  <= '0;
      end
      ST_SQL: begin
        mcand_r  <= SQ_W'(sq_src);
        mplier_r <= sq_src;
        bit_r    <= '0;
      end
      // Shift-and-add square, accumulated over the three components.
      ST_SQ: begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= {mcand_r[SQ_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[ROOT_W-1:1]};
        bit_r    <= bit_r + 6'd1;
        if (bit_r == 6'(ROOT_W-1)) begin
          comp_r <= comp_r + 2'd1;
        end
      end
      ST_RTL: begin
        rad_r  <= acc_r;
        rrem_r <= '0;
        root_r <= '0;
        bit_r  <= '0;
      end
      ST_RT: begin
        rrem_r <= rt_ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], rt_ge};
        rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
        bit_r  <= bit_r + 6'd1;
      end
      ST_DIVL: begin
        len_r   <= len_c;
        degen_r <= !big_poly || (len_c == '0);
        dcnt_r  <= '0;
        for (int i = 0; i < 3; i++) begin
          nrem_r[i] <= {1'b0, mag58(newell_r[i])};
          nq_r[i]   <= '0;
          cdiv_r[i] <= QUO_W'(cmag[i]) + QUO_W'(count_r[CNT_W-1:1]);
          crem_r[i] <= '0;
          cq_r[i]   <= '0;
        end
      end
      // Restoring division, one quotient bit per lane per cycle.
      ST_DIV: begin
        dcnt_r <= dcnt_r + 5'd1;
        for (int i = 0; i < 3; i++) begin
          nrem_r[i] <= (nge[i] ? (nrem_r[i] - {1'b0, len_r}) : nrem_r[i]) << 1;
          nq_r[i]   <= {nq_r[i][QUO_W-2:0], nge[i]};
          crem_r[i] <= cge[i] ? (crsh[i] - {1'b0, count_r}) : crsh[i];
          cq_r[i]   <= {cq_r[i][QUO_W-2:0], cge[i]};
          cdiv_r[i] <= {cdiv_r[i][QUO_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase

    // Load the result word.
    if (out_load) begin
      out_r.area              <= big_poly ? area_r[AREA_SUM_W-1:1] : '0;
      out_r.centroid_x        <= cent[0][COORD_W-1:0];
      out_r.centroid_y        <= cent[1][COORD_W-1:0];
      out_r.centroid_z        <= cent[2][COORD_W-1:0];
      out_r.unit_normal_x     <= degen_r ? '0 : nrm[0];
      out_r.unit_normal_y     <= degen_r ? '0 : nrm[1];
      out_r.unit_normal_z     <= degen_r ? '0 : nrm[2];
      out_r.vertices_used     <= count_r;
      out_r.normal_degenerate <= degen_r;
      out_r.vertex_overflow   <= ovf_r;
    end
  end

  assign out_empty = ~out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/polygon_area_centroid_normal_unit.sv
// ---------------------------------------------------------------------------
// Polygon area, centroid and unit normal: top level
// The first vertex of a polygon only updates its sums and the second adds its
// Newell terms; each later vertex also runs the bit-serial square and root unit.
// The last vertex adds the Newell root and the 31-step divisions.
// Synchronous active-low reset empties the queue and clears all polygon sums.
// ---------------------------------------------------------------------------
module polygon_area_centroid_normal_unit import pacn_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  output logic         in_full,
  input  vertex_word_t in_data,
  output logic         out_empty,
  input  logic         out_pop,
  output result_word_t out_data
);

  queue_wr_t q_wr;
  queue_rd_t q_rd;
  logic      q_full;
  logic      q_pop;

  // Front end: accept and classify vertices.
  pacn_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (q_full),
    .wr      (q_wr)
  );

  // Queue between the two halves.
  pacn_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .rd    (q_rd),
    .pop   (q_pop)
  );

  // Back end: arithmetic and result word.
  pacn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (q_rd),
    .pop       (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: rtl/pacn_checker.sv
// ---------------------------------------------------------------------------
// Polygon unit port checker
// Concurrent checks on the result side of the unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "polygon_area_centroid_normal_unit_defines.svh"

module pacn_checker import pacn_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         out_empty,
  input logic         out_pop,
  input result_word_t out_data
);

  // A waiting word holds until it is taken.
  property p_hold;
    !out_empty && !out_pop |=> !out_empty && $stable(out_data);
  endproperty

  // The vertex count is never zero and never above the maximum.
  property p_count;
    !out_empty |-> out_data.vertices_used != '0 &&
                   out_data.vertices_used <= CNT_W'(MAX_VERTICES);
  endproperty

  // A degenerate normal is all zero.
  property p_degen;
    !out_empty && out_data.normal_degenerate |->
      out_data.unit_normal_x == '0 && out_data.unit_normal_y == '0 &&
      out_data.unit_normal_z == '0;
  endproperty

  // Fewer than three vertices give no area and a degenerate normal.
  property p_small;
    !out_empty && out_data.vertices_used < CNT_W'(MIN_POLY) |->
      out_data.area == '0 && out_data.normal_degenerate;
  endproperty

  // No result word survives reset.
  `PACN_ASSERT_RST(a_reset_empty, !rst_n |=> out_empty, "result word present after reset")

  `PACN_ASSERT(a_hold, p_hold, "result word changed while waiting")

  `PACN_ASSERT(a_count, p_count, "vertex count out of range")

  `PACN_ASSERT(a_degen, p_degen, "degenerate normal not zero")

  `PACN_ASSERT(a_small, p_small, "small polygon result wrong")

endmodule

bind polygon_area_centroid_normal_unit pacn_checker u_pacn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
